// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the three-level priority queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// The expression must never be true.
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("assertion failed: forbidden condition");

`else

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`define ASSERT_NEVER(label, clk, rstn, expr)

`endif

`endif

// File: hdl/tlpq_pkg.sv
// ----------------------------------------------------------------------------
// Three-level priority queue package
// Sizes, status and mode codes, and shared types for the queue core.
// ----------------------------------------------------------------------------
package tlpq_pkg;

    localparam int DEPTH  = 128;
    localparam int LEVELS = 3;
    localparam int WORDS  = LEVELS * DEPTH;

    localparam int DATA_W = 32;
    localparam int PRI_W  = 2;
    localparam int STAT_W = 3;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LV_W   = $clog2(LEVELS);
    localparam int ADDR_W = $clog2(WORDS);

    localparam int S_TDATA_W = ((DATA_W + PRI_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + 7) / 8) * 8;

    typedef enum logic [STAT_W-1:0] {
        ST_ENQ    = 3'd0,
        ST_DEQ    = 3'd1,
        ST_FULL   = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_BADPRI = 3'd4
    } status_t;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    localparam logic [PRI_W-1:0] PRI_INVALID = '0;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        status_t           status;
    } op_t;

    function automatic logic [ADDR_W-1:0] level_addr(input logic [LV_W-1:0] lv,
                                                     input logic [PTR_W-1:0] ptr);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(lv) * ADDR_W'(DEPTH);
        return base + ADDR_W'(ptr);
    endfunction

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

endpackage

// File: hdl/three_level_priority_queue_core.sv
// ----------------------------------------------------------------------------
// Three-level priority queue core
// Three word FIFOs, one per priority level, sharing one storage RAM.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: s_tuser selects enqueue or dequeue, and
// s_tdata carries the word and its priority level (1 lowest, 3 highest).
// Every request produces exactly one result transfer on the m_ stream, with
// the status in m_tuser and the dequeued word in m_tdata (zero otherwise).
// An enqueue result is ready in the cycle after the request transfer; a dequeue
// waits for the registered RAM read, which then moves into the output
// register once it is free. One request is in flight at a time: enqueues can
// be taken every cycle while the receiver takes each result, and no new request
// is taken while a dequeue waits in the read state for the shared storage RAM.
// The result sits in an output register; while the receiver stalls, the
// result holds and no new request is taken unless the register frees up in
// that same cycle. Reset empties all three queues at once; RAM contents are
// left as they are and are never read before being written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module three_level_priority_queue_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [31:0] data_in, [33:32] priority_req, upper bits zero
    input  logic [tlpq_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] mode
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] data_out
    output logic [tlpq_pkg::M_TDATA_W-1:0]     m_tdata,
    // [2:0] status
    output logic [tlpq_pkg::STAT_W-1:0]        m_tuser
);

    import tlpq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t               state_reg;
    logic                 m_tvalid_reg;
    logic [DATA_W-1:0]    m_data_reg;
    status_t              m_status_reg;

    logic                 s_fire;
    logic                 out_free;
    logic                 out_load;
    op_t                  op;
    logic [DATA_W-1:0]    rd_data;
    logic [DATA_W-1:0]    data_in;
    logic [PRI_W-1:0]     priority_req;

    assign data_in      = s_tdata[DATA_W-1:0];
    assign priority_req = s_tdata[DATA_W+PRI_W-1:DATA_W];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign s_fire   = s_tvalid && s_tready;
    assign out_load = ((state_reg == S_IDLE) && s_fire && !op.rd_en)
                   || ((state_reg == S_READ) && out_free);

    tlpq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (s_fire),
        .mode    (s_tuser),
        .pri     (priority_req),
        .op      (op)
    );

    tlpq_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W),
        .WORDS  (WORDS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (s_fire && op.wr_en),
        .rd_en   (s_fire && op.rd_en),
        .addr    (op.addr),
        .wr_data (data_in),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        if (op.rd_en) begin
                            state_reg <= S_READ;
                        end else begin
                            m_data_reg   <= '0;
                            m_status_reg <= op.status;
                        end
                    end
                end
                S_READ: begin
                    if (out_free) begin
                        m_data_reg   <= rd_data;
                        m_status_reg <= ST_DEQ;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_data_reg);
    assign m_tuser  = m_status_reg;

    `ASSERT_NEVER(a_no_dual_access, aclk, aresetn, op.wr_en && op.rd_en)
    `ASSERT_NEXT(a_deq_enters_read, aclk, aresetn, s_fire && op.rd_en,
                 (state_reg == S_READ) && !s_tready)
    `ASSERT_IMPLIES(a_zero_unless_deq, aclk, aresetn, m_tvalid && (m_tuser != ST_DEQ),
                    m_tdata == '0)

endmodule

// File: hdl/tlpq_ram.sv
// ----------------------------------------------------------------------------
// Queue storage RAM
// Single-port synchronous RAM with a registered read, one access per cycle.
// ----------------------------------------------------------------------------
module tlpq_ram #(
    parameter int ADDR_W = 9,
    parameter int DATA_W = 32,
    parameter int WORDS  = 384
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [WORDS];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/tlpq_ctrl.sv
// ----------------------------------------------------------------------------
// Queue pointer control
// Keeps head, tail and occupancy per level, picks the RAM access and status
// for a request, and updates the pointers when the request is committed.
// ----------------------------------------------------------------------------
module tlpq_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         commit,
    input  logic                         mode,
    input  logic [tlpq_pkg::PRI_W-1:0]   pri,
    output tlpq_pkg::op_t                op
);

    import tlpq_pkg::*;

    logic [PTR_W-1:0] head_reg  [LEVELS];
    logic [PTR_W-1:0] tail_reg  [LEVELS];
    logic [CNT_W-1:0] count_reg [LEVELS];
    logic [PTR_W-1:0] head_next  [LEVELS];
    logic [PTR_W-1:0] tail_next  [LEVELS];
    logic [CNT_W-1:0] count_next [LEVELS];

    logic [LV_W-1:0] sel_lv;
    logic            found;

    always_comb begin
        op        = '0;
        op.status = ST_EMPTY;
        sel_lv    = '0;
        found     = 1'b0;
        if (mode == MODE_ENQ) begin
            if (pri == PRI_INVALID) begin
                op.status = ST_BADPRI;
            end else begin
                sel_lv = LV_W'(pri - PRI_W'(1));
                if (count_reg[sel_lv] == CNT_W'(DEPTH)) begin
                    op.status = ST_FULL;
                end else begin
                    op.wr_en  = 1'b1;
                    op.status = ST_ENQ;
                    op.addr   = level_addr(sel_lv, tail_reg[sel_lv]);
                end
            end
        end else begin
            for (int l = 0; l < LEVELS; l++) begin
                if (count_reg[l] != '0) begin
                    sel_lv = LV_W'(l);
                    found  = 1'b1;
                end
            end
            if (found) begin
                op.rd_en  = 1'b1;
                op.status = ST_DEQ;
                op.addr   = level_addr(sel_lv, head_reg[sel_lv]);
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LEVELS; l++) begin
            head_next[l]  = head_reg[l];
            tail_next[l]  = tail_reg[l];
            count_next[l] = count_reg[l];
            if (commit && (sel_lv == LV_W'(l))) begin
                if (op.wr_en) begin
                    tail_next[l]  = ring_next(tail_reg[l]);
                    count_next[l] = count_reg[l] + CNT_W'(1);
                end else if (op.rd_en) begin
                    head_next[l]  = ring_next(head_reg[l]);
                    count_next[l] = count_reg[l] - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < LEVELS; l++) begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
        end else begin
            for (int l = 0; l < LEVELS; l++) begin
                head_reg[l]  <= head_next[l];
                tail_reg[l]  <= tail_next[l];
                count_reg[l] <= count_next[l];
            end
        end
    end

endmodule
